### hw/rtl/tfei_pkg.sv
// ============================================================================
// tfei_pkg
// Shared constants, result codes and control bundles of the triangle-free
// edge inserter.
// ============================================================================
package tfei_pkg;

    localparam int MAX_VERTICES_DEF = 256;
    localparam int MAX_DEGREE_DEF   = 64;

    localparam int VERTEX_W   = 8;
    localparam int VCOUNT_W   = 9;
    localparam int COUNT_W    = 14;
    localparam int STATUS_W   = 2;
    localparam int WORD_BITS  = 64;
    localparam int WORD_SEL_W = 6;

    localparam logic [VCOUNT_W-1:0] VCOUNT_RESET = 9'd256;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ADDED    = 2'd0,
        STATUS_CLOSED   = 2'd1,
        STATUS_OVERFLOW = 2'd2,
        STATUS_INVALID  = 2'd3
    } status_t;

    // open-pair memory request
    typedef struct packed {
        logic rd;      // read word holding the pair bit
        logic close;   // with rd: clear the bit in the following cycle
        logic clear;   // sweep write of all ones
    } pair_ctl_t;

    // degree / neighbor memory request
    typedef struct packed {
        logic deg_rd;
        logic deg_wr;
        logic nb_rd;
        logic nb_wr;
    } vtx_ctl_t;

endpackage

### hw/rtl/tfei_pair_mem.sv
// ============================================================================
// tfei_pair_mem
// Open-pair bitset in a 64-bit wide synchronous memory, with a pipelined
// read-modify-write that clears one pair bit per cycle.
// ============================================================================
module tfei_pair_mem #(
    parameter int MAX_VERTICES = tfei_pkg::MAX_VERTICES_DEF,
    localparam int PW         = $clog2(MAX_VERTICES * MAX_VERTICES),
    localparam int PXW        = (PW > tfei_pkg::WORD_SEL_W) ? PW : tfei_pkg::WORD_SEL_W,
    localparam int PAIR_WORDS = (MAX_VERTICES * MAX_VERTICES + tfei_pkg::WORD_BITS - 1)
                                / tfei_pkg::WORD_BITS,
    localparam int WAW        = (PAIR_WORDS > 1) ? $clog2(PAIR_WORDS) : 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  tfei_pkg::pair_ctl_t ctl,
    input  logic [PXW-1:0]      pair_idx,
    input  logic [WAW-1:0]      clr_addr,
    output logic                pair_open
);

    localparam int WB = tfei_pkg::WORD_BITS;
    localparam int SW = tfei_pkg::WORD_SEL_W;

    logic [WB-1:0]  mem [PAIR_WORDS];
    logic [WB-1:0]  rdata_reg;
    logic [WB-1:0]  wb_data_reg;
    logic [WB-1:0]  cur_word;
    logic [WB-1:0]  wr_data;
    logic [WAW-1:0] rd_addr;
    logic [WAW-1:0] wr_addr;
    logic [WAW-1:0] pend_addr_reg;
    logic [WAW-1:0] wb_addr_reg;
    logic [SW-1:0]  pend_bit_reg;
    logic           pend_rd_reg;
    logic           pend_close_reg;
    logic           wb_valid_reg;
    logic           wr_en;

    assign rd_addr = WAW'(pair_idx >> SW);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    // the write issued at the edge that sampled this read is not in rdata yet
    always_comb
    begin
        if (wb_valid_reg && (wb_addr_reg == pend_addr_reg))
        begin
            cur_word = wb_data_reg;
        end
        else
        begin
            cur_word = rdata_reg;
        end
    end

    assign pair_open = cur_word[pend_bit_reg];

    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = pend_addr_reg;
        wr_data = cur_word & ~(WB'(1) << pend_bit_reg);
        if (ctl.clear)
        begin
            wr_en   = 1'b1;
            wr_addr = clr_addr;
            wr_data = '1;
        end
        else if (pend_rd_reg && pend_close_reg)
        begin
            wr_en = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_rd_reg    <= 1'b0;
            pend_close_reg <= 1'b0;
            wb_valid_reg   <= 1'b0;
        end
        else
        begin
            pend_rd_reg    <= ctl.rd;
            pend_close_reg <= ctl.close;
            wb_valid_reg   <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= rd_addr;
        pend_bit_reg  <= pair_idx[SW-1:0];
        wb_addr_reg   <= wr_addr;
        wb_data_reg   <= wr_data;
    end

`ifndef SYNTH
    a_clear_excludes_read: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctl.clear && ctl.rd))
        else $error("pair memory: sweep write overlaps a read");

    a_close_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.close |-> ctl.rd)
        else $error("pair memory: close without read");

    a_close_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (pend_rd_reg && pend_close_reg) |=>
            (wb_valid_reg && !wb_data_reg[$past(pend_bit_reg)]))
        else $error("pair memory: closed bit not written back");
`endif

endmodule

### hw/rtl/tfei_vertex_mem.sv
// ============================================================================
// tfei_vertex_mem
// Per-vertex degree memory and neighbor-list memory, both with one write
// port and one registered read port.
// ============================================================================
module tfei_vertex_mem #(
    parameter int MAX_VERTICES = tfei_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = tfei_pkg::MAX_DEGREE_DEF,
    localparam int VW   = $clog2(MAX_VERTICES),
    localparam int KW   = $clog2(MAX_DEGREE),
    localparam int DEGW = $clog2(MAX_DEGREE + 1),
    localparam int NAW  = VW + KW
) (
    input  logic               clk,
    input  tfei_pkg::vtx_ctl_t ctl,
    input  logic [VW-1:0]      deg_rd_addr,
    input  logic [VW-1:0]      deg_wr_addr,
    input  logic [DEGW-1:0]    deg_wr_data,
    output logic [DEGW-1:0]    deg_rdata,
    input  logic [NAW-1:0]     nb_rd_addr,
    input  logic [NAW-1:0]     nb_wr_addr,
    input  logic [VW-1:0]      nb_wr_data,
    output logic [VW-1:0]      nb_rdata
);

    // list slots are addressed {vertex, slot}
    localparam int NB_DEPTH = MAX_VERTICES << KW;

    logic [DEGW-1:0] deg_mem [MAX_VERTICES];
    logic [VW-1:0]   nb_mem  [NB_DEPTH];
    logic [DEGW-1:0] deg_rdata_reg;
    logic [VW-1:0]   nb_rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.deg_wr)
        begin
            deg_mem[deg_wr_addr] <= deg_wr_data;
        end
        if (ctl.deg_rd)
        begin
            deg_rdata_reg <= deg_mem[deg_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.nb_wr)
        begin
            nb_mem[nb_wr_addr] <= nb_wr_data;
        end
        if (ctl.nb_rd)
        begin
            nb_rdata_reg <= nb_mem[nb_rd_addr];
        end
    end

    assign deg_rdata = deg_rdata_reg;
    assign nb_rdata  = nb_rdata_reg;

endmodule

### hw/rtl/tfei_ctrl.sv
// ============================================================================
// tfei_ctrl
// Item sequencer: reset sweep, pair and degree checks, neighbor-list walk
// feeding pair closes, list append, and the result register.
// ============================================================================
module tfei_ctrl #(
    parameter int MAX_VERTICES = tfei_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = tfei_pkg::MAX_DEGREE_DEF,
    localparam int VW         = $clog2(MAX_VERTICES),
    localparam int KW         = $clog2(MAX_DEGREE),
    localparam int DEGW       = $clog2(MAX_DEGREE + 1),
    localparam int NAW        = VW + KW,
    localparam int PW         = $clog2(MAX_VERTICES * MAX_VERTICES),
    localparam int PXW        = (PW > tfei_pkg::WORD_SEL_W) ? PW : tfei_pkg::WORD_SEL_W,
    localparam int PAIR_WORDS = (MAX_VERTICES * MAX_VERTICES + tfei_pkg::WORD_BITS - 1)
                                / tfei_pkg::WORD_BITS,
    localparam int WAW        = (PAIR_WORDS > 1) ? $clog2(PAIR_WORDS) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [tfei_pkg::VERTEX_W-1:0] in_u,
    input  logic [tfei_pkg::VERTEX_W-1:0] in_v,
    input  logic [tfei_pkg::VCOUNT_W-1:0] vertex_count,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tfei_pkg::status_t             out_status,
    output logic [tfei_pkg::COUNT_W-1:0]  out_count,
    output tfei_pkg::pair_ctl_t           pair_ctl,
    output logic [PXW-1:0]                pair_idx,
    output logic [WAW-1:0]                pair_clr_addr,
    input  logic                          pair_open,
    output tfei_pkg::vtx_ctl_t            vtx_ctl,
    output logic [VW-1:0]                 deg_rd_addr,
    output logic [VW-1:0]                 deg_wr_addr,
    output logic [DEGW-1:0]               deg_wr_data,
    input  logic [DEGW-1:0]               deg_rdata,
    output logic [NAW-1:0]                nb_rd_addr,
    output logic [NAW-1:0]                nb_wr_addr,
    output logic [VW-1:0]                 nb_wr_data,
    input  logic [VW-1:0]                 nb_rdata
);

    localparam int CW        = tfei_pkg::COUNT_W;
    localparam int CLR_DEPTH = (PAIR_WORDS > MAX_VERTICES) ? PAIR_WORDS : MAX_VERTICES;
    localparam int CLRW      = $clog2(CLR_DEPTH);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_CHK_PAIR,
        S_CHK_DEG,
        S_WALK,
        S_DRAIN,
        S_APP_U,
        S_APP_V,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [CLRW-1:0]   clr_reg, clr_next;
    logic [VW-1:0]     u_reg, u_next;
    logic [VW-1:0]     v_reg, v_next;
    logic [DEGW-1:0]   degu_reg, degu_next;
    logic [DEGW-1:0]   degv_reg, degv_next;
    logic [KW-1:0]     k_reg, k_next;
    logic              phase_reg, phase_next;
    logic              b_valid_reg, b_valid_next;
    logic [VW-1:0]     b_other_reg, b_other_next;
    tfei_pkg::status_t status_reg, status_next;
    logic [CW-1:0]     edges_reg, edges_next;
    logic              out_valid_reg, out_valid_next;
    tfei_pkg::status_t out_status_reg, out_status_next;
    logic [CW-1:0]     out_count_reg, out_count_next;

    logic              bad_pair;
    logic [VW-1:0]     cur_x;
    logic [DEGW-1:0]   cur_d;
    logic [VW-1:0]     pair_a;
    logic [VW-1:0]     pair_b;
    logic [VW-1:0]     pair_lo;
    logic [VW-1:0]     pair_hi;

    assign bad_pair = (in_u == in_v)
                   || (tfei_pkg::VCOUNT_W'(in_u) >= vertex_count)
                   || (tfei_pkg::VCOUNT_W'(in_v) >= vertex_count)
                   || (32'(in_u) >= MAX_VERTICES)
                   || (32'(in_v) >= MAX_VERTICES);

    assign cur_x = phase_reg ? v_reg : u_reg;
    assign cur_d = phase_reg ? degv_reg : degu_reg;

    assign pair_lo  = (pair_a < pair_b) ? pair_a : pair_b;
    assign pair_hi  = (pair_a < pair_b) ? pair_b : pair_a;
    assign pair_idx = PXW'(pair_lo) * PXW'(MAX_VERTICES) + PXW'(pair_hi);

    assign pair_clr_addr = WAW'(clr_reg);
    assign in_ready      = (state_reg == S_IDLE);
    assign out_valid     = out_valid_reg;
    assign out_status    = out_status_reg;
    assign out_count     = out_count_reg;

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        u_next          = u_reg;
        v_next          = v_reg;
        degu_next       = degu_reg;
        degv_next       = degv_reg;
        k_next          = k_reg;
        phase_next      = phase_reg;
        b_valid_next    = 1'b0;
        b_other_next    = b_other_reg;
        status_next     = status_reg;
        edges_next      = edges_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;

        pair_ctl    = '0;
        pair_a      = u_reg;
        pair_b      = v_reg;
        vtx_ctl     = '0;
        deg_rd_addr = u_reg;
        deg_wr_addr = u_reg;
        deg_wr_data = degu_reg + DEGW'(1);
        nb_rd_addr  = {cur_x, k_reg};
        nb_wr_addr  = {u_reg, degu_reg[KW-1:0]};
        nb_wr_data  = v_reg;

        // walk stage B: neighbor w of x is back, close (w, other) unless w is other
        if (b_valid_reg && (nb_rdata != b_other_reg))
        begin
            pair_ctl.rd    = 1'b1;
            pair_ctl.close = 1'b1;
            pair_a         = nb_rdata;
            pair_b         = b_other_reg;
        end

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_CLEAR:
            begin
                pair_ctl.clear = (32'(clr_reg) < PAIR_WORDS);
                vtx_ctl.deg_wr = (32'(clr_reg) < MAX_VERTICES);
                deg_wr_addr    = VW'(clr_reg);
                deg_wr_data    = '0;
                if (clr_reg == CLRW'(CLR_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + CLRW'(1);
                end
            end

            S_IDLE:
            begin
                if (in_valid)
                begin
                    u_next = VW'(in_u);
                    v_next = VW'(in_v);
                    if (bad_pair)
                    begin
                        status_next = tfei_pkg::STATUS_INVALID;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        pair_ctl.rd    = 1'b1;
                        pair_a         = VW'(in_u);
                        pair_b         = VW'(in_v);
                        vtx_ctl.deg_rd = 1'b1;
                        deg_rd_addr    = VW'(in_u);
                        state_next     = S_CHK_PAIR;
                    end
                end
            end

            S_CHK_PAIR:
            begin
                degu_next = deg_rdata;
                if (!pair_open)
                begin
                    status_next = tfei_pkg::STATUS_CLOSED;
                    state_next  = S_DONE;
                end
                else
                begin
                    vtx_ctl.deg_rd = 1'b1;
                    deg_rd_addr    = v_reg;
                    state_next     = S_CHK_DEG;
                end
            end

            S_CHK_DEG:
            begin
                degv_next = deg_rdata;
                if ((degu_reg >= DEGW'(MAX_DEGREE)) || (deg_rdata >= DEGW'(MAX_DEGREE)))
                begin
                    status_next = tfei_pkg::STATUS_OVERFLOW;
                    state_next  = S_DONE;
                end
                else
                begin
                    k_next     = '0;
                    phase_next = 1'b0;
                    state_next = S_WALK;
                end
            end

            // stage A: fetch one list entry per cycle, u's list then v's
            S_WALK:
            begin
                if (DEGW'(k_reg) < cur_d)
                begin
                    vtx_ctl.nb_rd = 1'b1;
                    k_next        = k_reg + KW'(1);
                    b_valid_next  = 1'b1;
                    b_other_next  = phase_reg ? u_reg : v_reg;
                end
                else if (!phase_reg)
                begin
                    phase_next = 1'b1;
                    k_next     = '0;
                end
                else
                begin
                    state_next = S_DRAIN;
                end
            end

            S_DRAIN:
            begin
                if (!b_valid_reg)
                begin
                    pair_ctl.rd    = 1'b1;
                    pair_ctl.close = 1'b1;
                    state_next     = S_APP_U;
                end
            end

            S_APP_U:
            begin
                vtx_ctl.nb_wr  = 1'b1;
                vtx_ctl.deg_wr = 1'b1;
                state_next     = S_APP_V;
            end

            S_APP_V:
            begin
                vtx_ctl.nb_wr  = 1'b1;
                vtx_ctl.deg_wr = 1'b1;
                nb_wr_addr     = {v_reg, degv_reg[KW-1:0]};
                nb_wr_data     = u_reg;
                deg_wr_addr    = v_reg;
                deg_wr_data    = degv_reg + DEGW'(1);
                edges_next     = edges_reg + CW'(1);
                status_next    = tfei_pkg::STATUS_ADDED;
                state_next     = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_count_next  = edges_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            u_reg          <= '0;
            v_reg          <= '0;
            degu_reg       <= '0;
            degv_reg       <= '0;
            k_reg          <= '0;
            phase_reg      <= 1'b0;
            b_valid_reg    <= 1'b0;
            b_other_reg    <= '0;
            status_reg     <= tfei_pkg::STATUS_ADDED;
            edges_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= tfei_pkg::STATUS_ADDED;
            out_count_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            u_reg          <= u_next;
            v_reg          <= v_next;
            degu_reg       <= degu_next;
            degv_reg       <= degv_next;
            k_reg          <= k_next;
            phase_reg      <= phase_next;
            b_valid_reg    <= b_valid_next;
            b_other_reg    <= b_other_next;
            status_reg     <= status_next;
            edges_reg      <= edges_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_count_reg  <= out_count_next;
        end
    end

`ifndef SYNTH
    a_walk_degrees_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WALK) |->
            ((degu_reg < DEGW'(MAX_DEGREE)) && (degv_reg < DEGW'(MAX_DEGREE))))
        else $error("ctrl: walking a full neighbor list");

    a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !b_valid_reg)
        else $error("ctrl: item taken with a close still in flight");

    a_edges_only_on_add: assert property (@(posedge clk) disable iff (!rst_n)
        (edges_reg != $past(edges_reg)) |-> ($past(state_reg) == S_APP_V))
        else $error("ctrl: edge counter moved outside an add");
`endif

endmodule

### hw/rtl/triangle_free_edge_inserter.sv
// ============================================================================
// triangle_free_edge_inserter
// Grows a triangle-free graph one candidate vertex pair at a time.
// ============================================================================
// Usage:
//   s_axis carries one candidate pair per item; m_axis returns exactly one
//   result item per input item, in order: a status code and the running edge
//   count. The cfg channel writes vertex_count (always ready), to be done
//   while no item is in flight.
//   One item at a time. The time an added edge takes is set by the walk
//   over both neighbor lists, which closes one pair per cycle through the
//   open-pair memory's read-modify-write. Invalid pairs, closed pairs and
//   degree overflow end without the walk.
//   Reset: the open-pair memory is swept to all ones and the degree memory
//   to zero; s_axis_tready stays low meanwhile. vertex_count resets to 256.
//   Stall: the result waits in the output register; the next item is taken
//   and processed, and its result holds until m_axis_tready frees the
//   register.
// ============================================================================
module triangle_free_edge_inserter #(
    parameter int MAX_VERTICES = tfei_pkg::MAX_VERTICES_DEF,
    parameter int MAX_DEGREE   = tfei_pkg::MAX_DEGREE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] vertex_u, [15:8] vertex_v
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [1:0] status, [15:2] edge_count
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data        // vertex_count
);

    localparam int VW         = $clog2(MAX_VERTICES);
    localparam int KW         = $clog2(MAX_DEGREE);
    localparam int DEGW       = $clog2(MAX_DEGREE + 1);
    localparam int NAW        = VW + KW;
    localparam int PW         = $clog2(MAX_VERTICES * MAX_VERTICES);
    localparam int PXW        = (PW > tfei_pkg::WORD_SEL_W) ? PW : tfei_pkg::WORD_SEL_W;
    localparam int PAIR_WORDS = (MAX_VERTICES * MAX_VERTICES + tfei_pkg::WORD_BITS - 1)
                                / tfei_pkg::WORD_BITS;
    localparam int WAW        = (PAIR_WORDS > 1) ? $clog2(PAIR_WORDS) : 1;

    logic [tfei_pkg::VCOUNT_W-1:0] vertex_count_reg;

    tfei_pkg::status_t             out_status;
    logic [tfei_pkg::COUNT_W-1:0]  out_count;
    tfei_pkg::pair_ctl_t           pair_ctl;
    logic [PXW-1:0]                pair_idx;
    logic [WAW-1:0]                pair_clr_addr;
    logic                          pair_open;
    tfei_pkg::vtx_ctl_t            vtx_ctl;
    logic [VW-1:0]                 deg_rd_addr;
    logic [VW-1:0]                 deg_wr_addr;
    logic [DEGW-1:0]               deg_wr_data;
    logic [DEGW-1:0]               deg_rdata;
    logic [NAW-1:0]                nb_rd_addr;
    logic [NAW-1:0]                nb_wr_addr;
    logic [VW-1:0]                 nb_wr_data;
    logic [VW-1:0]                 nb_rdata;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vertex_count_reg <= tfei_pkg::VCOUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            vertex_count_reg <= cfg_data;
        end
    end

    tfei_ctrl #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_axis_tvalid),
        .in_ready      (s_axis_tready),
        .in_u          (s_axis_tdata[7:0]),
        .in_v          (s_axis_tdata[15:8]),
        .vertex_count  (vertex_count_reg),
        .out_valid     (m_axis_tvalid),
        .out_ready     (m_axis_tready),
        .out_status    (out_status),
        .out_count     (out_count),
        .pair_ctl      (pair_ctl),
        .pair_idx      (pair_idx),
        .pair_clr_addr (pair_clr_addr),
        .pair_open     (pair_open),
        .vtx_ctl       (vtx_ctl),
        .deg_rd_addr   (deg_rd_addr),
        .deg_wr_addr   (deg_wr_addr),
        .deg_wr_data   (deg_wr_data),
        .deg_rdata     (deg_rdata),
        .nb_rd_addr    (nb_rd_addr),
        .nb_wr_addr    (nb_wr_addr),
        .nb_wr_data    (nb_wr_data),
        .nb_rdata      (nb_rdata)
    );

    tfei_pair_mem #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_pair_mem (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (pair_ctl),
        .pair_idx  (pair_idx),
        .clr_addr  (pair_clr_addr),
        .pair_open (pair_open)
    );

    tfei_vertex_mem #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_DEGREE   (MAX_DEGREE)
    ) u_vertex_mem (
        .clk         (clk),
        .ctl         (vtx_ctl),
        .deg_rd_addr (deg_rd_addr),
        .deg_wr_addr (deg_wr_addr),
        .deg_wr_data (deg_wr_data),
        .deg_rdata   (deg_rdata),
        .nb_rd_addr  (nb_rd_addr),
        .nb_wr_addr  (nb_wr_addr),
        .nb_wr_data  (nb_wr_data),
        .nb_rdata    (nb_rdata)
    );

    assign m_axis_tdata = {out_count, out_status};

endmodule

### tb/testbench.sv
// ============================================================================
// Triangle-free edge inserter testbench
// Streams candidate vertex pairs into the block and checks every status and
// edge count against a local model of the open-pair set, the degrees and the
// neighbor lists. Covers vertex-count limits, triangle closure and degree
// overflow, then random pairs under several vertex counts and idle patterns.
// ============================================================================
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_VERTICES   = tfei_pkg::MAX_VERTICES_DEF;
    localparam int MAX_DEGREE     = tfei_pkg::MAX_DEGREE_DEF;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 150;
    localparam int RANDOM_ITEMS   = 120;

    typedef logic [tfei_pkg::VERTEX_W-1:0] vertex_t;

    typedef struct {
        vertex_t                      u;
        vertex_t                      v;
        tfei_pkg::status_t            status;
        logic [tfei_pkg::COUNT_W-1:0] edge_count;
    } insertion_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [15:0]                   s_axis_tdata = '0;    // [7:0] vertex_u, [15:8] vertex_v
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [15:0]                   m_axis_tdata;         // [1:0] status, [15:2] edge_count
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tfei_pkg::VCOUNT_W-1:0] cfg_data = '0;       // vertex_count

    // graph model
    bit                            open_pair [MAX_VERTICES*MAX_VERTICES];
    logic [6:0]                    vertex_degree [MAX_VERTICES];
    vertex_t                       neighbor [MAX_VERTICES][MAX_DEGREE];
    logic [tfei_pkg::COUNT_W-1:0]  edges_total = '0;
    logic [tfei_pkg::VCOUNT_W-1:0] vertex_count_model = tfei_pkg::VCOUNT_RESET;

    insertion_t                    predicted_results [$];
    int                            errors = 0;
    int                            send_idle_pct = 0;
    int                            sink_stall_pct = 0;
    int                            quiet_cycles = 0;

    triangle_free_edge_inserter u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int pair_slot(input vertex_t a, input vertex_t b);
        return (a < b) ? int'({a, b}) : int'({b, a});
    endfunction

    // close (w,other) for every neighbor w of x that is not other
    function automatic void close_around(input vertex_t x, input vertex_t other);
        for (int k = 0; k < int'(vertex_degree[x]); k++)
            if (neighbor[x][k] != other)
                open_pair[pair_slot(neighbor[x][k], other)] = 1'b0;
    endfunction

    function automatic insertion_t predict_insertion(input vertex_t u, input vertex_t v);
        insertion_t r;
        int         lim;
        lim = (int'(vertex_count_model) < MAX_VERTICES) ? int'(vertex_count_model)
                                                         : MAX_VERTICES;
        r.u = u;
        r.v = v;
        if (u == v || int'(u) >= lim || int'(v) >= lim)
            r.status = tfei_pkg::STATUS_INVALID;
        else if (!open_pair[pair_slot(u, v)])
            r.status = tfei_pkg::STATUS_CLOSED;
        else if (int'(vertex_degree[u]) >= MAX_DEGREE || int'(vertex_degree[v]) >= MAX_DEGREE)
            r.status = tfei_pkg::STATUS_OVERFLOW;
        else
        begin
            close_around(u, v);
            close_around(v, u);
            open_pair[pair_slot(u, v)] = 1'b0;
            neighbor[u][vertex_degree[u]] = v;
            neighbor[v][vertex_degree[v]] = u;
            vertex_degree[u]++;
            vertex_degree[v]++;
            edges_total++;
            r.status = tfei_pkg::STATUS_ADDED;
        end
        r.edge_count = edges_total;
        return r;
    endfunction

    task automatic send_pair(input vertex_t u, input vertex_t v);
        @(negedge clk);
        if (int'($urandom_range(99)) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            do @(negedge clk); while (int'($urandom_range(99)) < send_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {v, u};
        do @(posedge clk); while (!s_axis_tready);
        predicted_results.push_back(predict_insertion(u, v));
    endtask

    task automatic drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (predicted_results.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_vertex_count(input logic [tfei_pkg::VCOUNT_W-1:0] value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        vertex_count_model = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_vertex_count_limits();
        send_pair(8'd0, 8'd0);
        send_pair(8'd255, 8'd255);
        write_vertex_count(9'd0);
        send_pair(8'd0, 8'd1);
        write_vertex_count(9'd1);
        send_pair(8'd1, 8'd0);
        write_vertex_count(9'd2);
        send_pair(8'd0, 8'd1);
        send_pair(8'd1, 8'd0);
        send_pair(8'd0, 8'd2);
        send_pair(8'd255, 8'd0);
        // counts above the vertex limit clamp to it
        write_vertex_count(9'd511);
        send_pair(8'd254, 8'd255);
        send_pair(8'd255, 8'd254);
        write_vertex_count(tfei_pkg::VCOUNT_RESET);
    endtask

    task automatic test_triangle_closure();
        send_pair(8'd10, 8'd11);
        send_pair(8'd11, 8'd12);
        send_pair(8'd10, 8'd12);
        send_pair(8'd12, 8'd11);
        send_pair(8'd12, 8'd13);
        send_pair(8'd13, 8'd10);
    endtask

    // star around one hub fills its list, then both endpoint orders overflow
    task automatic test_degree_overflow();
        for (int k = 1; k <= MAX_DEGREE; k++)
            send_pair(8'd100, vertex_t'(100 + k));
        send_pair(8'd101, 8'd102);
        send_pair(8'd100, 8'd165);
        send_pair(8'd200, 8'd100);
        drain_results();
    endtask

    task automatic test_random_pairs(input int phase,
                                     input logic [tfei_pkg::VCOUNT_W-1:0] count,
                                     input int items);
        int      lim;
        vertex_t u;
        vertex_t v;
        write_vertex_count(count);
        case (phase % 4)
            0:
            begin
                send_idle_pct  = 0;
                sink_stall_pct = 0;
            end
            1:
            begin
                send_idle_pct  = 54;
                sink_stall_pct = 0;
            end
            2:
            begin
                send_idle_pct  = 0;
                sink_stall_pct = 54;
            end
            default:
            begin
                send_idle_pct  = 16;
                sink_stall_pct = 16;
            end
        endcase
        lim = (int'(count) < MAX_VERTICES) ? int'(count) : MAX_VERTICES;
        for (int i = 0; i < items; i++)
        begin
            if (lim >= 2 && int'($urandom_range(99)) < 85)
            begin
                u = vertex_t'($urandom_range(lim - 1));
                v = vertex_t'($urandom_range(lim - 1));
            end
            else
            begin
                u = vertex_t'($urandom_range(255));
                v = vertex_t'($urandom_range(255));
            end
            send_pair(u, v);
        end
        drain_results();
    endtask

    always @(negedge clk)
        m_axis_tready <= (int'($urandom_range(99)) >= sink_stall_pct);

    always @(posedge clk)
    begin : result_check
        insertion_t                   want;
        tfei_pkg::status_t            got_status;
        logic [tfei_pkg::COUNT_W-1:0] got_count;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got_status = tfei_pkg::status_t'(m_axis_tdata[1:0]);
            got_count  = m_axis_tdata[15:2];
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, got status %0d count %0d",
                         $realtime, got_status, got_count);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                if (got_status !== want.status)
                begin
                    $display("%0t: pair (%0d,%0d) status expected %0d, got %0d",
                             $realtime, want.u, want.v, want.status, got_status);
                    errors++;
                end
                if (got_count !== want.edge_count)
                begin
                    $display("%0t: pair (%0d,%0d) edge_count expected %0d, got %0d",
                             $realtime, want.u, want.v, want.edge_count, got_count);
                    errors++;
                end
            end
        end
    end

    // reset sweep and the slowest item fit well inside the limit
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        logic [tfei_pkg::VCOUNT_W-1:0] phase_counts [8];
        phase_counts = '{9'd256, 9'd511, 9'd2, 9'd40, 9'd256, 9'd9, 9'd100, 9'd256};
        foreach (open_pair[i])
            open_pair[i] = 1'b1;
        foreach (vertex_degree[i])
            vertex_degree[i] = '0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_vertex_count_limits();
        test_triangle_closure();
        test_degree_overflow();
        for (int p = 0; p < 8; p++)
            test_random_pairs(p, phase_counts[p], RANDOM_ITEMS);

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
